>>> src/rdp_pkg.sv
`timescale 1ns / 1ps

package rdp_pkg;

    localparam logic [1:0] KIND_REFILL = 2'd0;
    localparam logic [1:0] KIND_DRAW   = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;
    localparam logic [1:0] KIND_PULL   = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam int CODE_W = 6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] random_fraction;
        logic [3:0]  pull_rank;
        logic [1:0]  pull_suit;
    } cmd_t;

    typedef struct packed {
        logic [3:0] card_rank;
        logic [1:0] card_suit;
        logic [1:0] status;
        logic [5:0] remaining;
    } result_t;

endpackage

>>> src/rdp_ram.sv
`timescale 1ns / 1ps

module rdp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 52
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> src/random_draw_pool_without_replacement_core.sv
`timescale 1ns / 1ps

// refill, and draw, peek or pull on an empty pool: result the cycle after start, no busy
// draw and peek: slot multiply, pool ram read, then write back (draw only)
// pull: scans the pool slots one by one, one pool ram read per cycle
// results appear on done for one cycle after the last busy cycle; the receiver cannot stall
// reset: pool in order via per-slot valid flops, count full, no clearing pass needed
module random_draw_pool_without_replacement_core
    import rdp_pkg::*;
#(
    parameter int POOL_SIZE = 52
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int IDXW = $clog2(POOL_SIZE);
    localparam int CW   = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_SIZE);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DRAW_RD = 2'd1;
    localparam logic [1:0] ST_DRAW_WB = 2'd2;
    localparam logic [1:0] ST_SCAN    = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [POOL_SIZE-1:0] valid_reg, valid_next;
    logic                 done_reg, done_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    result_t              result_reg, result_next;
    logic [1:0]           kind_reg, kind_next;
    logic [CODE_W-1:0]    want_reg, want_next;
    logic [IDXW-1:0]      slot_reg, slot_next;
    logic [IDXW-1:0]      pos_reg, pos_next;
    logic [IDXW-1:0]      a_q_reg;
    logic [IDXW-1:0]      b_q_reg;

    logic [IDXW-1:0]      addr_a;
    logic [IDXW-1:0]      last_idx;
    logic [CODE_W-1:0]    rdata_a;
    logic [CODE_W-1:0]    rdata_b;
    logic [CODE_W-1:0]    code_a;
    logic [CODE_W-1:0]    last_code;
    logic                 we;
    logic [IDXW-1:0]      waddr;
    logic [CW+31:0]       product;
    logic [CODE_W-1:0]    want_in;
    logic [6:0]           want_ext;
    logic [6:0]           count_ext;
    logic [IDXW-1:0]      start_pos;
    logic [CW-1:0]        count_dec;

    rdp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (POOL_SIZE)
    ) u_pool_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (last_code),
        .raddr_a (addr_a),
        .rdata_a (rdata_a),
        .raddr_b (last_idx),
        .rdata_b (rdata_b)
    );

    assign count_dec = count_reg - CW'(1);
    assign last_idx  = IDXW'(count_dec);
    assign addr_a    = (state_reg == ST_DRAW_RD) ? slot_reg : pos_reg;

    // unwritten slots still hold their reset code
    assign code_a    = valid_reg[a_q_reg] ? rdata_a : CODE_W'(a_q_reg);
    assign last_code = valid_reg[b_q_reg] ? rdata_b : CODE_W'(b_q_reg);

    assign product   = CW'(count_reg) * cmd.random_fraction;
    assign want_in   = CODE_W'({cmd.pull_rank, cmd.pull_suit});
    assign want_ext  = 7'(want_in);
    assign count_ext = 7'(count_reg);
    assign start_pos = (want_ext < count_ext) ? IDXW'(want_in) : last_idx;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        cmp_vld_next = cmp_vld_reg;
        result_next  = result_reg;
        kind_next    = kind_reg;
        want_next    = want_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        we           = 1'b0;
        waddr        = a_q_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = cmd.kind;
                    want_next = want_in;
                    unique case (cmd.kind)
                        KIND_REFILL:
                        begin
                            valid_next  = '0;
                            count_next  = FULL_COUNT;
                            done_next   = 1'b1;
                            result_next = '{card_rank: 4'd0, card_suit: 2'd0,
                                            status: STATUS_OK,
                                            remaining: 6'(FULL_COUNT)};
                        end
                        KIND_DRAW, KIND_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '{card_rank: 4'd0, card_suit: 2'd0,
                                                status: STATUS_EMPTY,
                                                remaining: 6'(count_reg)};
                            end
                            else
                            begin
                                slot_next  = IDXW'(product[CW+31:32]);
                                state_next = ST_DRAW_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '{card_rank: 4'd0, card_suit: 2'd0,
                                                status: STATUS_NOT_FOUND,
                                                remaining: 6'(count_reg)};
                            end
                            else
                            begin
                                pos_next     = start_pos;
                                cmp_vld_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_DRAW_RD:
            begin
                state_next = ST_DRAW_WB;
            end
            ST_DRAW_WB:
            begin
                if (kind_reg == KIND_DRAW)
                begin
                    we                  = 1'b1;
                    valid_next[a_q_reg] = 1'b1;
                    count_next          = count_dec;
                end
                done_next   = 1'b1;
                result_next = '{card_rank: code_a[5:2], card_suit: code_a[1:0],
                                status: STATUS_OK, remaining: 6'(count_next)};
                state_next  = ST_IDLE;
            end
            default:
            begin
                cmp_vld_next = 1'b1;
                pos_next     = (pos_reg == '0) ? pos_reg : pos_reg - IDXW'(1);
                if (cmp_vld_reg)
                begin
                    if (code_a == want_reg)
                    begin
                        we                  = 1'b1;
                        valid_next[a_q_reg] = 1'b1;
                        count_next          = count_dec;
                        done_next           = 1'b1;
                        result_next = '{card_rank: want_reg[5:2], card_suit: want_reg[1:0],
                                        status: STATUS_OK, remaining: 6'(count_dec)};
                        state_next  = ST_IDLE;
                    end
                    else if (a_q_reg == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{card_rank: 4'd0, card_suit: 2'd0,
                                        status: STATUS_NOT_FOUND,
                                        remaining: 6'(count_reg)};
                        state_next  = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= FULL_COUNT;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        kind_reg   <= kind_next;
        want_reg   <= want_next;
        slot_reg   <= slot_next;
        pos_reg    <= pos_next;
        a_q_reg    <= addr_a;
        b_q_reg    <= last_idx;
    end

endmodule

>>> sim/random_draw_pool_without_replacement_core_tb.sv
`timescale 1ns / 1ps

module random_draw_pool_without_replacement_core_tb;
    import rdp_pkg::*;

    localparam int POOL_SIZE = 52;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 445;

    typedef struct {
        cmd_t    cmd;
        int      reps;
        bit      rand_frac;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    logic [5:0] deck [POOL_SIZE];
    int         cards_left;
    result_t    pending_results [$];
    plan_row_t  plan [$];
    int         mismatches = 0;
    int         cycle_count = 0;

    random_draw_pool_without_replacement_core #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("random_draw_pool_without_replacement_core regression: fail");
            $finish;
        end
    end

    function automatic void refill_deck();
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            deck[k] = 6'(k);
        end
        cards_left = POOL_SIZE;
    endfunction

    function automatic result_t apply_to_pool(cmd_t c);
        result_t     r;
        logic [63:0] prod;
        logic [5:0]  want;
        int          slot;
        int          pos;
        r = '0;
        case (c.kind)
            KIND_REFILL:
            begin
                refill_deck();
            end
            KIND_DRAW, KIND_PEEK:
            begin
                if (cards_left == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    prod = 64'(cards_left) * 64'(c.random_fraction);
                    slot = int'(prod[63:32]);
                    r.card_rank = deck[slot][5:2];
                    r.card_suit = deck[slot][1:0];
                    r.status = STATUS_OK;
                    if (c.kind == KIND_DRAW)
                    begin
                        cards_left--;
                        deck[slot] = deck[cards_left];
                    end
                end
            end
            default:
            begin
                want = {c.pull_rank, c.pull_suit};
                r.status = STATUS_NOT_FOUND;
                if (cards_left > 0)
                begin
                    pos = (int'(want) < cards_left) ? int'(want) : cards_left - 1;
                    while (pos >= 0 && deck[pos] != want)
                    begin
                        pos--;
                    end
                    if (pos >= 0)
                    begin
                        cards_left--;
                        deck[pos] = deck[cards_left];
                        r.card_rank = want[5:2];
                        r.card_suit = want[1:0];
                        r.status = STATUS_OK;
                    end
                end
            end
        endcase
        r.remaining = 6'(cards_left);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result %p", result));
            end
            else
            begin
                result_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.card_rank !== exp_r.card_rank)
                begin
                    flag_mismatch($sformatf("card_rank got %0d want %0d",
                                            result.card_rank, exp_r.card_rank));
                end
                if (result.card_suit !== exp_r.card_suit)
                begin
                    flag_mismatch($sformatf("card_suit got %0d want %0d",
                                            result.card_suit, exp_r.card_suit));
                end
                if (result.status !== exp_r.status)
                begin
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            result.status, exp_r.status));
                end
                if (result.remaining !== exp_r.remaining)
                begin
                    flag_mismatch($sformatf("remaining got %0d want %0d",
                                            result.remaining, exp_r.remaining));
                end
            end
        end
    end

    // drive one item, record its result at acceptance, then maybe idle
    task automatic issue_item(input cmd_t c, input int idle_pct, input bit typed,
                              input result_t want);
        result_t predicted;
        int      gap;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_to_pool(c);
        pending_results.push_back(typed ? want : predicted);
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void add_row(input cmd_t c, input int reps, input bit rand_frac,
                                    input bit typed, input result_t want);
        plan_row_t row;
        row.cmd = c;
        row.reps = reps;
        row.rand_frac = rand_frac;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    initial
    begin
        cmd_t c;
        int   idle_pct [4];
        int   pick;

        idle_pct = '{0, 67, 0, 34};
        refill_deck();

        // full pool extremes
        add_row({KIND_PEEK, 32'h0, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_OK, 6'd52});
        add_row({KIND_PEEK, 32'hFFFF_FFFF, 4'd0, 2'd0}, 1, 0, 1,
                {4'd12, 2'd3, STATUS_OK, 6'd52});
        add_row({KIND_DRAW, 32'hFFFF_FFFF, 4'd15, 2'd3}, 1, 0, 1,
                {4'd12, 2'd3, STATUS_OK, 6'd51});
        add_row({KIND_DRAW, 32'h0, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_OK, 6'd50});
        // pulls of removed and nonexistent cards
        add_row({KIND_PULL, 32'h0, 4'd12, 2'd3}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_NOT_FOUND, 6'd50});
        add_row({KIND_PULL, 32'hFFFF_FFFF, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_NOT_FOUND, 6'd50});
        add_row({KIND_PULL, 32'h0, 4'd15, 2'd3}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_NOT_FOUND, 6'd50});
        add_row({KIND_PULL, 32'h0, 4'd13, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_NOT_FOUND, 6'd50});
        // card moved to the bottom slot, full scan
        add_row({KIND_PULL, 32'h0, 4'd12, 2'd2}, 1, 0, 1,
                {4'd12, 2'd2, STATUS_OK, 6'd49});
        add_row({KIND_PULL, 32'h0, 4'd5, 2'd1}, 1, 0, 0, '0);
        add_row({KIND_PEEK, 32'h0, 4'd0, 2'd0}, 1, 1, 0, '0);
        add_row({KIND_REFILL, 32'hFFFF_FFFF, 4'd15, 2'd3}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_OK, 6'd52});
        add_row({KIND_PULL, 32'h0, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_OK, 6'd51});
        add_row({KIND_REFILL, 32'h0, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_OK, 6'd52});
        // drain to empty
        add_row({KIND_DRAW, 32'h0, 4'd0, 2'd0}, POOL_SIZE, 1, 0, '0);
        add_row({KIND_DRAW, 32'h8000_0000, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_EMPTY, 6'd0});
        add_row({KIND_PEEK, 32'hFFFF_FFFF, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_EMPTY, 6'd0});
        add_row({KIND_PULL, 32'h0, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_NOT_FOUND, 6'd0});
        add_row({KIND_REFILL, 32'h0, 4'd0, 2'd0}, 1, 0, 1,
                {4'd0, 2'd0, STATUS_OK, 6'd52});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            for (int n = 0; n < plan[i].reps; n++)
            begin
                c = plan[i].cmd;
                if (plan[i].rand_frac)
                begin
                    c.random_fraction = $urandom;
                end
                issue_item(c, 0, plan[i].typed, plan[i].want);
            end
        end
        // hold off until the pool has answered everything
        wait_for_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                c.random_fraction = $urandom;
                c.pull_rank = 4'($urandom_range(15));
                c.pull_suit = 2'($urandom_range(3));
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    c.random_fraction = '0;
                end
                else if (pick < 16)
                begin
                    c.random_fraction = '1;
                end
                pick = $urandom_range(99);
                if ((cards_left == 0 && pick < 12) || pick == 0)
                begin
                    c.kind = KIND_REFILL;
                end
                else if (pick < 55)
                begin
                    c.kind = KIND_DRAW;
                end
                else if (pick < 75)
                begin
                    c.kind = KIND_PEEK;
                end
                else
                begin
                    c.kind = KIND_PULL;
                    // mostly name a card still in the pool
                    if (cards_left > 0 && $urandom_range(99) < 70)
                    begin
                        {c.pull_rank, c.pull_suit} = deck[$urandom_range(cards_left - 1)];
                    end
                end
                issue_item(c, idle_pct[ph], 1'b0, '0);
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("random_draw_pool_without_replacement_core regression: pass");
        end
        else
        begin
            $display("random_draw_pool_without_replacement_core regression: fail");
        end
        $finish;
    end

endmodule
